@@ sv/tsa_pkg.sv @@
// Shared types, widths and register codes for the three-point stencil block.
`default_nettype none

package tsa_pkg;

  // Field widths.
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int VALUE_W   = PROD_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_TAPS  = 3;

  // Coefficient reset values in Q4.12: -1.0, 2.0, -1.0.
  localparam logic signed [COEF_W-1:0] COEF_LEFT_RESET   = -16'sd4096;
  localparam logic signed [COEF_W-1:0] COEF_CENTER_RESET = 16'sd8192;
  localparam logic signed [COEF_W-1:0] COEF_RIGHT_RESET  = -16'sd4096;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_LEFT   = 2'd0,
    REG_COEF_CENTER = 2'd1,
    REG_COEF_RIGHT  = 2'd2
  } cfg_reg_t;

  // One slot of the sample window. A flush slot has elem low.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       elem;
    logic                       last;
  } tap_t;

endpackage

`default_nettype wire

@@ sv/tsa_cell.sv @@
// One window cell: holds a sample slot and registers its weighted product.
`default_nettype none

module tsa_cell (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               shift,
  input  wire logic signed [tsa_pkg::COEF_W-1:0]  coef,
  input  wire tsa_pkg::tap_t                      tap_in,
  output tsa_pkg::tap_t                           tap_out,
  output logic signed [tsa_pkg::PROD_W-1:0]       prod
);
  import tsa_pkg::*;

  // Slot flags are control state; the sample itself needs no reset.
  always_ff @(posedge clk) begin
    if (shift) begin
      tap_out.sample <= tap_in.sample;
    end
    if (rst) begin
      tap_out.elem <= 1'b0;
      tap_out.last <= 1'b0;
    end else if (shift) begin
      tap_out.elem <= tap_in.elem;
      tap_out.last <= tap_in.last;
    end
  end

  // Product of the incoming sample, taken with the coefficient of this position.
  always_ff @(posedge clk) begin
    if (shift) begin
      prod <= PROD_W'(coef) * PROD_W'(tap_in.sample);
    end
  end

endmodule

`default_nettype wire

@@ sv/three_point_stencil_apply.sv @@
// Top level: tridiagonal stencil over a streamed vector using a chain of three cells.
// The last item's own result comes from the flush slot that follows that item.
// Throughput: one item per cycle unless output stalls; each vector adds a flush slot.
// Reset clears the window flags and output stage and loads the coefficient defaults.
`default_nettype none

module three_point_stencil_apply (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [tsa_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic                                 is_last,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [tsa_pkg::VALUE_W-1:0]        value,
  output logic                                      last_out,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [tsa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [tsa_pkg::COEF_W-1:0]           cfg_data
);
  import tsa_pkg::*;

  logic signed [COEF_W-1:0] coef_left;
  logic signed [COEF_W-1:0] coef_center;
  logic signed [COEF_W-1:0] coef_right;
  logic signed [COEF_W-1:0] cell_coef [NUM_TAPS];
  logic signed [PROD_W-1:0] cell_prod [NUM_TAPS];
  tap_t                     cell_in   [NUM_TAPS];
  tap_t                     cell_q    [NUM_TAPS];
  tap_t                     token;

  logic                     flush_pend;
  logic                     in_acc;
  logic                     shift;
  logic                     p_valid;
  logic                     p_last;
  logic                     p_lmask;
  logic                     p_rmask;
  logic                     p_adv;
  logic                     o_adv;
  logic signed [VALUE_W-1:0] sum;

  // Configuration writes are always taken; an unknown index is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_left   <= COEF_LEFT_RESET;
      coef_center <= COEF_CENTER_RESET;
      coef_right  <= COEF_RIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEF_LEFT:   coef_left   <= cfg_data;
        REG_COEF_CENTER: coef_center <= cfg_data;
        REG_COEF_RIGHT:  coef_right  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake and stage advance. A flush slot follows every last item.
  assign o_adv    = !out_valid || out_ready;
  assign p_adv    = !p_valid || o_adv;
  assign in_ready = p_adv && !flush_pend;
  assign in_acc   = in_valid && in_ready;
  assign shift    = in_acc || (flush_pend && p_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_pend <= 1'b0;
    end else if (flush_pend && p_adv) begin
      flush_pend <= 1'b0;
    end else if (in_acc && is_last) begin
      flush_pend <= 1'b1;
    end
  end

  // Slot entering the window: the input item, or an empty flush slot.
  always_comb begin
    token.sample = flush_pend ? '0 : sample;
    token.elem   = !flush_pend;
    token.last   = !flush_pend && is_last;
  end

  // Window chain: position 0 is the following sample, 1 the current, 2 the preceding.
  assign cell_coef[0] = coef_right;
  assign cell_coef[1] = coef_center;
  assign cell_coef[2] = coef_left;

  always_comb begin
    cell_in[0] = token;
    for (int k = 1; k < NUM_TAPS; k++) begin
      cell_in[k] = cell_q[k-1];
    end
  end

  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
    tsa_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (shift),
      .coef    (cell_coef[k]),
      .tap_in  (cell_in[k]),
      .tap_out (cell_q[k]),
      .prod    (cell_prod[k])
    );
  end

  // Product stage: a result is due when the center slot holds a real element.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_adv) begin
      p_valid <= shift && cell_in[1].elem;
    end
  end

  // Neighbor terms drop at vector boundaries.
  always_ff @(posedge clk) begin
    if (shift) begin
      p_last  <= cell_in[1].last;
      p_rmask <= !cell_in[1].last;
      p_lmask <= cell_in[2].elem && !cell_in[2].last;
    end
  end

  // Sum of the three weighted terms, full precision.
  always_comb begin
    sum = VALUE_W'(cell_prod[1]);
    if (p_rmask) begin
      sum = sum + VALUE_W'(cell_prod[0]);
    end
    if (p_lmask) begin
      sum = sum + VALUE_W'(cell_prod[2]);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_adv) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv && p_valid) begin
      value    <= sum;
      last_out <= p_last;
    end
  end

  // A last item is always followed by its flush slot.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && is_last) |=> flush_pend)
    else $error("flush slot not scheduled after last item");

  // The last result of a vector never carries a right-hand term.
  assert property (@(posedge clk) disable iff (rst)
    (p_valid && p_last) |-> !p_rmask)
    else $error("right term kept on last result");

  // A stalled product stage keeps its result.
  assert property (@(posedge clk) disable iff (rst)
    (p_valid && !p_adv) |=> (p_valid && $stable(p_last)))
    else $error("product stage lost a stalled result");

endmodule

`default_nettype wire
